### rtl/fat_chain_allocator_unit_assert.svh
// Assertion macros for the allocation table unit.
`ifndef FAT_CHAIN_ALLOCATOR_UNIT_ASSERT_SVH
`define FAT_CHAIN_ALLOCATOR_UNIT_ASSERT_SVH
// implication checked every clock, disabled in reset
`define FCA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define FCA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/fca_pkg.sv
// Package: types, codes and constants of the allocation table unit.
package fca_pkg;
  localparam int TableEntries = 1024;
  localparam int BlockBytes   = 512;
  localparam int IdxW  = $clog2(TableEntries);
  localparam int CntW  = IdxW + 1;
  localparam int BlkSh = $clog2(BlockBytes);
  localparam int LenW  = 20;

  localparam logic [2:0] CMD_ALLOC    = 3'd0;
  localparam logic [2:0] CMD_APPEND   = 3'd1;
  localparam logic [2:0] CMD_FREE     = 3'd2;
  localparam logic [2:0] CMD_TRUNCATE = 3'd3;
  localparam logic [2:0] CMD_LOAD     = 3'd4;
  localparam logic [2:0] CMD_READ     = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_BROKEN = 2'd2;
  localparam logic [1:0] ST_BADLEN = 2'd3;

  typedef struct packed {
    logic [2:0]      cmd;
    logic [9:0]      head;
    logic [9:0]      count;
    logic [LenW-1:0] new_length;
    logic [LenW-1:0] old_length;
    logic            entry_used;
    logic            entry_eof;
    logic [9:0]      entry_next;
  } fca_in_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [9:0]      index;
    logic [LenW-1:0] length_out;
    logic [10:0]     freed_count;
    logic            used_out;
    logic            eof_out;
    logic [9:0]      next_out;
  } fca_out_t;

  // classified word handed from front to back
  typedef struct packed {
    fca_in_t          word;
    logic             trivial;   // result known without table access
    logic [1:0]       t_status;
    logic [LenW-1:0]  t_length;
    logic [CntW-1:0]  keep;      // blocks kept by truncate
  } fca_job_t;

  function automatic logic [CntW-1:0] blocks_of(input logic [LenW-1:0] len);
    logic [LenW-1:0] q;
    begin
      q = (len - LenW'(1)) >> BlkSh;
      if (len == '0) blocks_of = CntW'(1);
      else blocks_of = CntW'(q + LenW'(1));
    end
  endfunction
endpackage

### rtl/fca_front.sv
// Front end: accepts commands, classifies them, two-entry queue to the back end.
module fca_front import fca_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  fca_in_t  in_word,
  output logic     in_ready,
  output logic     q_valid,
  output fca_job_t q_job,
  input  logic     q_take
);
  fca_job_t        q_mem [2];
  logic            wr_ptr, rd_ptr;
  logic [1:0]      fill;
  fca_job_t        job;
  logic [CntW-1:0] kb, ob;

  always_comb begin
    kb = blocks_of(in_word.new_length);
    ob = blocks_of(in_word.old_length);
    job = '0;
    job.word = in_word;
    job.keep = kb;
    job.t_status = ST_OK;
    case (in_word.cmd)
      CMD_APPEND: job.trivial = (in_word.count == '0);
      CMD_TRUNCATE: begin
        if (in_word.new_length > in_word.old_length) begin
          job.trivial = 1'b1;
          job.t_status = ST_BADLEN;
          job.t_length = in_word.old_length;
        end else if (kb == ob) begin
          job.trivial = 1'b1;
          job.t_length = in_word.new_length;
        end
      end
      CMD_ALLOC, CMD_FREE, CMD_LOAD, CMD_READ: job.trivial = 1'b0;
      default: job.trivial = 1'b1;
    endcase
  end

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_job    = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) q_mem[wr_ptr] <= job;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= ~wr_ptr;
      if (q_take) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(in_valid && in_ready) - 2'(q_take);
    end
  end
endmodule

### rtl/fca_back.sv
// Back end: sequencer that walks, scans and updates the allocation table.
module fca_back import fca_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [10:0] limit_cfg,
  input  logic        q_valid,
  input  fca_job_t    q_job,
  output logic        q_take,
  output logic        res_valid,
  output fca_out_t    res_word,
  output logic        idle
);
  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_CLEAR = 12'b000000000010,
    S_RD    = 12'b000000000100,
    S_WALK  = 12'b000000001000,
    S_COUNT = 12'b000000010000,
    S_LINK  = 12'b000000100000,
    S_FREE  = 12'b000001000000,
    S_TSEEK = 12'b000010000000,
    S_ALLOC = 12'b000100000000,
    S_READ  = 12'b001000000000,
    S_MARK  = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  logic [11:0]     mem [TableEntries];
  logic [11:0]     rdata;
  logic [IdxW-1:0] raddr;
  logic            we;
  logic [IdxW-1:0] waddr;
  logic [11:0]     wdata;

  state_t          state, ret;
  fca_job_t        job;
  logic [CntW-1:0] scan, steps, n, lim;
  logic [IdxW-1:0] cur, prev;
  logic [CntW-1:0] nfree, done_n;
  fca_out_t        res;
  logic [IdxW-1:0] scan_m1, link_next;
  logic            scan_free, tail_cut;

  assign lim = (limit_cfg < CntW'(TableEntries)) ? limit_cfg : CntW'(TableEntries);

  // scan points one entry ahead of the data in rdata
  assign scan_m1   = scan[IdxW-1:0] - 1'b1;
  assign scan_free = (scan != '0) && !rdata[11];
  // truncate tail reached and entries follow it
  assign tail_cut  = (steps + 1'b1 == job.keep) && (n != job.keep);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // read address presented combinationally, data valid next cycle
  always_comb begin
    raddr = cur;
    if (state == S_COUNT || state == S_ALLOC || state == S_LINK)
      raddr = scan[IdxW-1:0];
  end

  assign q_take    = (state == S_IDLE) && q_valid;
  assign res_valid = (state == S_DONE);
  assign res_word  = res;
  assign idle      = (state == S_IDLE) && !q_valid;

  always_comb begin
    we = 1'b0; waddr = cur; wdata = rdata;
    case (state)
      S_CLEAR: begin we = 1'b1; waddr = scan[IdxW-1:0]; wdata = '0; end
      S_IDLE: if (q_valid && q_job.word.cmd == CMD_LOAD) begin
        we = 1'b1; waddr = q_job.word.head;
        wdata = {q_job.word.entry_used, q_job.word.entry_eof, q_job.word.entry_next};
      end
      S_ALLOC: if (scan_free) begin
        we = 1'b1; waddr = scan_m1; wdata = {2'b11, rdata[9:0]};
      end
      // link previous entry to the one just found
      S_LINK: if (scan_free) begin
        we = 1'b1; waddr = prev; wdata = {2'b10, scan_m1};
      end
      S_MARK: begin we = 1'b1; waddr = prev; wdata = {2'b11, link_next}; end
      S_TSEEK: if (tail_cut) begin
        we = 1'b1; wdata = {rdata[11], 1'b1, rdata[9:0]};
      end
      S_FREE: begin we = 1'b1; wdata = {2'b00, rdata[9:0]}; end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      scan  <= '0;
      ret   <= S_IDLE;
    end else begin
      case (state)
        S_CLEAR: begin
          scan <= scan + 1'b1;
          if (scan == CntW'(TableEntries - 1)) state <= S_IDLE;
        end
        S_IDLE: if (q_valid) begin
          job <= q_job;
          cur <= q_job.word.head;
          steps <= '0;
          scan <= '0;
          nfree <= '0;
          done_n <= '0;
          if (q_job.trivial) begin
            res <= {q_job.t_status, 10'd0, q_job.t_length, 23'd0};
            state <= S_DONE;
          end else begin
            case (q_job.word.cmd)
              CMD_ALLOC: begin state <= S_ALLOC; res <= {ST_NOFREE, 53'd0}; end
              CMD_LOAD: begin state <= S_DONE; res <= '0; end
              CMD_READ: begin state <= S_RD; ret <= S_READ; res <= '0; end
              default: begin state <= S_RD; ret <= S_WALK; res <= '0; end
            endcase
          end
        end
        S_RD: state <= ret;   // memory read latency
        S_READ: begin
          res.used_out <= rdata[11];
          res.eof_out  <= rdata[10];
          res.next_out <= rdata[9:0];
          state <= S_DONE;
        end
        S_ALLOC: begin
          // rdata holds entry scan_m1; scan is already the next read address
          if (scan_free) begin
            res.status <= ST_OK;
            res.index <= scan_m1;
            state <= S_DONE;
          end else if (scan >= lim) state <= S_DONE;
          else scan <= scan + 1'b1;
        end
        S_WALK: begin
          // validate chain; cur holds entry, rdata its contents
          if (!rdata[11] || steps == CntW'(TableEntries)) begin
            res.status <= ST_BROKEN; state <= S_DONE;
          end else if (rdata[10]) begin
            n <= steps + 1'b1;
            cur <= job.word.head;
            steps <= '0;
            case (job.word.cmd)
              CMD_APPEND: begin prev <= cur; state <= S_COUNT; end
              CMD_FREE: begin state <= S_RD; ret <= S_FREE; end
              default: if (steps + 1'b1 < job.keep) begin
                res.status <= ST_BROKEN; state <= S_DONE;
              end else begin state <= S_RD; ret <= S_TSEEK; end
            endcase
          end else begin
            steps <= steps + 1'b1; cur <= rdata[9:0]; state <= S_RD;
          end
        end
        S_COUNT: begin
          if (scan_free) nfree <= nfree + 1'b1;
          if (scan >= lim) begin
            if (nfree + CntW'(scan_free) < CntW'(job.word.count)) begin
              res.status <= ST_NOFREE; state <= S_DONE;
            end else begin scan <= '0; state <= S_LINK; end
          end else scan <= scan + 1'b1;
        end
        S_LINK: begin
          if (scan_free) begin
            done_n <= done_n + 1'b1;
            prev <= scan_m1;
            link_next <= rdata[9:0];
            res.index <= scan_m1;
            if (done_n + 1'b1 == CntW'(job.word.count)) state <= S_MARK;
          end
          scan <= scan + 1'b1;
        end
        // last appended entry becomes the chain end
        S_MARK: state <= S_DONE;
        S_TSEEK: begin
          if (steps + 1'b1 == job.keep) begin
            res.length_out <= job.word.new_length;
            if (n == job.keep) state <= S_DONE;
            else begin
              cur <= rdata[9:0]; steps <= job.keep; state <= S_RD; ret <= S_FREE;
            end
          end else begin steps <= steps + 1'b1; cur <= rdata[9:0]; state <= S_RD; end
        end
        S_FREE: begin
          res.freed_count <= res.freed_count + 1'b1;
          if (steps + 1'b1 == n) state <= S_DONE;
          else begin steps <= steps + 1'b1; cur <= rdata[9:0]; state <= S_RD; end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/fat_chain_allocator_unit.sv
// Allocation table unit: cleared table, alloc, append, free, truncate, load, read.
// Usage: pulse start with cmd word while busy is low; one result word per command
// appears on result with done high for one cycle; the receiver cannot stall.
// entries_in_use_we writes the entry limit; only write while the block is idle.
// Reset clears the 1024-entry table with a pass over every entry after rst falls;
// commands taken during that pass wait in the queue. Busy is high during rst.
// Load and trivial commands need no chain walk; read does one table read; alloc
// scans entries up to the limit and takes the first free one that it finds.
// A chain walk reads one chain entry at a time (one port, registered read).
// Append walks the chain, counts free entries up to the limit, then links them;
// free and truncate walk the chain, then walk it again to free the entries.
// A two-word queue sits between the command front end and the table sequencer.
// One command is in the sequencer at a time; the next is taken the cycle after
// the previous result word.
// Config words are taken at the edge where entries_in_use_we is high.
// Results outside a command's scope read as zero.
// Busy stays high while the queue holds two words.
// Width of the entry limit register is 11 bits, reset value 1024.
module fat_chain_allocator_unit import fca_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  fca_in_t     cmd_in,
  output logic        busy,
  output logic        done,
  output fca_out_t    result,
  input  logic        entries_in_use_we,
  input  logic [10:0] entries_in_use
);
  `include "fat_chain_allocator_unit_assert.svh"
  logic [10:0] limit_reg;
  logic        in_ready, q_valid, q_take, idle_b;
  fca_job_t    q_job;

  always_ff @(posedge clk) begin
    if (rst) limit_reg <= 11'd1024;
    else if (entries_in_use_we) limit_reg <= entries_in_use;
  end

  assign busy = rst || !in_ready;

  fca_front u_front (
    .clk, .rst, .in_valid(start), .in_word(cmd_in), .in_ready,
    .q_valid, .q_job, .q_take
  );

  fca_back u_back (
    .clk, .rst, .limit_cfg(limit_reg), .q_valid, .q_job, .q_take,
    .res_valid(done), .res_word(result), .idle(idle_b)
  );

  `FCA_ASSERT_IMP(a_take_needs_valid, q_take, q_valid)
  `FCA_ASSERT_NXT(a_done_single, done, !done)
  `FCA_ASSERT_IMP(a_idle_no_done, idle_b, !done)
endmodule
